FILE: rtl/kbsp_pkg.sv
// Shared types, constants and Q30 arithmetic helpers for the Klein bottle point pipeline.
package kbsp_pkg;

  // Width of the signed Q30 working values (sines, cosines, powers, products)
  localparam int QW = 34;
  // Width of the signed inner sums before the last multiply
  localparam int IW = 42;
  // Number of coordinate lanes
  localparam int NUM_LANES = 3;

  typedef logic signed [QW-1:0] q30_t;
  typedef logic signed [IW-1:0] wide_t;
  typedef logic signed [19:0]   coord_t;

  localparam q30_t ONE_Q30 = 34'sd1073741824;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  // Taylor coefficients round(2^30 / k!)
  localparam q30_t SIN_COEF [5] = '{
    34'sd178956971, 34'sd8947849, 34'sd213044, 34'sd2959, 34'sd27
  };
  localparam q30_t COS_COEF [6] = '{
    34'sd536870912, 34'sd44739243, 34'sd1491308, 34'sd26631, 34'sd296, 34'sd2
  };

  // Final divide by 15: reciprocal ceil(2^27/15), valid for quotients below saturation
  localparam int unsigned RECIP_SHIFT = 27;
  localparam logic [23:0] RECIP_15 = 24'd8947849;
  localparam logic [22:0] SAT_N = 23'd7864335;
  localparam logic [19:0] OUT_MAX_MAG = 20'd524287;
  localparam logic [19:0] OUT_NEG_MAG = 20'd524288;
  localparam coord_t OUT_MAX = 20'sh7FFFF;
  localparam coord_t OUT_MIN = 20'sh80000;

  // Lane factors: x is -2, y is -1, z is +2
  localparam logic [NUM_LANES-1:0] LANE_NEG = 3'b011;
  localparam logic [NUM_LANES-1:0] LANE_SHL = 3'b101;

  // Q30 product, rounded to nearest with ties away from zero
  function automatic q30_t qmul(input q30_t a, input q30_t b);
    logic [QW-1:0]   ma;
    logic [QW-1:0]   mb;
    logic [2*QW-1:0] pr;
    logic [QW-1:0]   m;
    ma = a[QW-1] ? (~a + 1'b1) : a;
    mb = b[QW-1] ? (~b + 1'b1) : b;
    pr = (2*QW)'(ma) * (2*QW)'(mb) + (2*QW)'(1 << 29);
    m  = pr[QW+29:30];
    return (a[QW-1] ^ b[QW-1]) ? -$signed(m) : $signed(m);
  endfunction

  // Clamp to [0, 1.0]
  function automatic q30_t clamp_unit(input q30_t v);
    if (v < 0) begin
      return '0;
    end else if (v > ONE_Q30) begin
      return ONE_Q30;
    end
    return v;
  endfunction

endpackage

FILE: rtl/kbsp_sincos.sv
// Eight-stage pipelined sine and cosine of an angle given as a fraction of a full turn.
module kbsp_sincos
  import kbsp_pkg::*;
#(
  parameter int ANGLE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic [ANGLE_BITS-1:0] angle_i,
  output q30_t                  sin_o,
  output q30_t                  cos_o
);

  localparam int RW = ANGLE_BITS - 2;

  logic [RW+30:0] tprod;
  logic [1:0]     quad_q [1:7];
  q30_t           t_q    [1:7];
  q30_t           t2_q   [2:7];
  q30_t           sp_q   [3:7];
  q30_t           cp_q   [3:7];
  q30_t           s_w;
  q30_t           c_w;

  // Scale the in-quadrant part to Q30 radians
  assign tprod = (RW+31)'(angle_i[RW-1:0]) * (RW+31)'(HALF_PI_Q30);

  // Stage 1 and 2: angle, then its square
  always_ff @(posedge clk_i) begin
    quad_q[1] <= angle_i[ANGLE_BITS-1:ANGLE_BITS-2];
    t_q[1]    <= $signed(QW'(tprod[RW+30:RW]));
    quad_q[2] <= quad_q[1];
    t_q[2]    <= t_q[1];
    t2_q[2]   <= qmul(t_q[1], t_q[1]);
  end

  // Stages 3 to 7: one Horner step per stage for both series
  always_ff @(posedge clk_i) begin
    sp_q[3] <= SIN_COEF[3] - qmul(t2_q[2], SIN_COEF[4]);
    cp_q[3] <= COS_COEF[4] - qmul(t2_q[2], COS_COEF[5]);
    for (int k = 4; k <= 6; k++) begin
      sp_q[k] <= SIN_COEF[6-k] - qmul(t2_q[k-1], sp_q[k-1]);
      cp_q[k] <= COS_COEF[7-k] - qmul(t2_q[k-1], cp_q[k-1]);
    end
    sp_q[7] <= ONE_Q30 - qmul(t2_q[6], sp_q[6]);
    cp_q[7] <= COS_COEF[0] - qmul(t2_q[6], cp_q[6]);
    for (int k = 3; k <= 7; k++) begin
      quad_q[k] <= quad_q[k-1];
      t_q[k]    <= t_q[k-1];
      t2_q[k]   <= t2_q[k-1];
    end
  end

  // Stage 8: finish, clamp and fold in the quadrant
  assign s_w = clamp_unit(qmul(t_q[7], sp_q[7]));
  assign c_w = clamp_unit(ONE_Q30 - qmul(t2_q[7], cp_q[7]));

  always_ff @(posedge clk_i) begin
    unique case (quad_q[7])
      2'd0: begin
        sin_o <= s_w;
        cos_o <= c_w;
      end
      2'd1: begin
        sin_o <= c_w;
        cos_o <= -s_w;
      end
      2'd2: begin
        sin_o <= -s_w;
        cos_o <= -c_w;
      end
      default: begin
        sin_o <= -c_w;
        cos_o <= s_w;
      end
    endcase
  end

endmodule

FILE: rtl/klein_bottle_surface_point_top.sv
// Klein bottle surface point: pipelined evaluation of (x, y, z) from angles u and v.
//
//  port group       dir  handshake        payload
//  request          in   start / busy     angle_u_i, angle_v_i
//  result           out  done_o strobe    coord_x_o, coord_y_o, coord_z_o
//
//  One request is taken every cycle; busy stays low.
//  Each request runs through the sine/cosine stages, stages P1..P7 for the powers
//  and inner sums, then M1..M5 for the final product, rounding, divide by 15 and saturation.
//  Most stages hold one or more 34x34 multiplies; the result shows for one cycle.
//  Reset clears only the valid chain; data registers carry no reset.
module klein_bottle_surface_point_top
  import kbsp_pkg::*;
#(
  parameter int ANGLE_BITS      = 16,
  parameter int COORD_FRAC_BITS = 14
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [ANGLE_BITS-1:0] angle_u_i,
  input  logic [ANGLE_BITS-1:0] angle_v_i,
  output logic                  done_o,
  output coord_t                coord_x_o,
  output coord_t                coord_y_o,
  output coord_t                coord_z_o
);

  localparam int LAT      = 20;
  localparam int SHIFT_K  = 30 - COORD_FRAC_BITS;
  localparam int MW       = IW + QW - 29;
  localparam logic [MW:0] HALF_DEN = (MW+1)'(15) << (SHIFT_K - 1);

  logic [LAT-1:0] vld_q;
  q30_t su_w, cu_w, sv_w, cv_w;

  // Request valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], start & ~busy};
    end
  end

  assign busy   = 1'b0;
  assign done_o = vld_q[LAT-1];

  kbsp_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_u (
    .clk_i  (clk_i),
    .angle_i(angle_u_i),
    .sin_o  (su_w),
    .cos_o  (cu_w)
  );

  kbsp_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_v (
    .clk_i  (clk_i),
    .angle_i(angle_v_i),
    .sin_o  (sv_w),
    .cos_o  (cv_w)
  );

  // Stage P1
  q30_t p1_su_q, p1_cu_q, p1_sv_q, p1_cv_q, p1_cu2_q, p1_cuv_q, p1_cvsu_q, p1_cusu_q;
  always_ff @(posedge clk_i) begin
    p1_su_q   <= su_w;
    p1_cu_q   <= cu_w;
    p1_sv_q   <= sv_w;
    p1_cv_q   <= cv_w;
    p1_cu2_q  <= qmul(cu_w, cu_w);
    p1_cuv_q  <= qmul(cu_w, cv_w);
    p1_cvsu_q <= qmul(cv_w, su_w);
    p1_cusu_q <= qmul(cu_w, su_w);
  end

  // Stage P2
  q30_t  p2_su_q, p2_cu_q, p2_sv_q, p2_cv_q, p2_cu2_q, p2_cvsu_q;
  q30_t  p2_cu3_q, p2_cu4_q, p2_a_q, p2_cu2cv_q;
  wide_t p2_zin_q;
  always_ff @(posedge clk_i) begin
    p2_su_q    <= p1_su_q;
    p2_cu_q    <= p1_cu_q;
    p2_sv_q    <= p1_sv_q;
    p2_cv_q    <= p1_cv_q;
    p2_cu2_q   <= p1_cu2_q;
    p2_cvsu_q  <= p1_cvsu_q;
    p2_cu3_q   <= qmul(p1_cu2_q, p1_cu_q);
    p2_cu4_q   <= qmul(p1_cu2_q, p1_cu2_q);
    p2_a_q     <= qmul(p1_cuv_q, p1_su_q);
    p2_cu2cv_q <= qmul(p1_cu2_q, p1_cv_q);
    p2_zin_q   <= IW'(3) * IW'(ONE_Q30) + IW'(5) * IW'(p1_cusu_q);
  end

  // Stage P3
  q30_t  p3_su_q, p3_cu_q, p3_sv_q, p3_cv_q, p3_cu2_q, p3_cvsu_q, p3_a_q, p3_cu2cv_q;
  q30_t  p3_cu5_q, p3_cu6_q, p3_t1_q, p3_cu4su_q, p3_cu3cv_q;
  wide_t p3_zin_q;
  always_ff @(posedge clk_i) begin
    p3_su_q    <= p2_su_q;
    p3_cu_q    <= p2_cu_q;
    p3_sv_q    <= p2_sv_q;
    p3_cv_q    <= p2_cv_q;
    p3_cu2_q   <= p2_cu2_q;
    p3_cvsu_q  <= p2_cvsu_q;
    p3_a_q     <= p2_a_q;
    p3_cu2cv_q <= p2_cu2cv_q;
    p3_zin_q   <= p2_zin_q;
    p3_cu5_q   <= qmul(p2_cu4_q, p2_cu_q);
    p3_cu6_q   <= qmul(p2_cu4_q, p2_cu2_q);
    p3_t1_q    <= qmul(p2_cu4_q, p2_cv_q);
    p3_cu4su_q <= qmul(p2_cu4_q, p2_su_q);
    p3_cu3cv_q <= qmul(p2_cu3_q, p2_cv_q);
  end

  // Stage P4
  q30_t  p4_su_q, p4_cu_q, p4_sv_q, p4_cv_q, p4_cu2_q, p4_a_q, p4_cu2cv_q, p4_t1_q;
  q30_t  p4_cu4su_q, p4_tc_q, p4_qt1_q, p4_cu6su_q, p4_cu3cvsu_q;
  wide_t p4_zin_q;
  always_ff @(posedge clk_i) begin
    p4_su_q      <= p3_su_q;
    p4_cu_q      <= p3_cu_q;
    p4_sv_q      <= p3_sv_q;
    p4_cv_q      <= p3_cv_q;
    p4_cu2_q     <= p3_cu2_q;
    p4_a_q       <= p3_a_q;
    p4_cu2cv_q   <= p3_cu2cv_q;
    p4_t1_q      <= p3_t1_q;
    p4_cu4su_q   <= p3_cu4su_q;
    p4_zin_q     <= p3_zin_q;
    p4_tc_q      <= qmul(p3_cvsu_q, p3_cu5_q);
    p4_qt1_q     <= qmul(p3_t1_q, p3_cu2_q);
    p4_cu6su_q   <= qmul(p3_cu6_q, p3_su_q);
    p4_cu3cvsu_q <= qmul(p3_cu3cv_q, p3_su_q);
  end

  // Stage P5: x inner sum, B term
  q30_t  p5_su_q, p5_cu_q, p5_sv_q, p5_cv_q, p5_a_q, p5_cu2cv_q, p5_tc_q, p5_qt2_q;
  q30_t  p5_cu3cvsu_q;
  wide_t p5_zin_q, p5_xin_q, p5_b_q;
  always_ff @(posedge clk_i) begin
    p5_su_q      <= p4_su_q;
    p5_cu_q      <= p4_cu_q;
    p5_sv_q      <= p4_sv_q;
    p5_cv_q      <= p4_cv_q;
    p5_a_q       <= p4_a_q;
    p5_cu2cv_q   <= p4_cu2cv_q;
    p5_tc_q      <= p4_tc_q;
    p5_cu3cvsu_q <= p4_cu3cvsu_q;
    p5_zin_q     <= p4_zin_q;
    p5_qt2_q     <= qmul(p4_tc_q, p4_cu2_q);
    p5_xin_q     <= IW'(3) * IW'(p4_cv_q) - IW'(30) * IW'(p4_su_q)
                  + IW'(90) * IW'(p4_cu4su_q) - IW'(60) * IW'(p4_cu6su_q)
                  + IW'(5) * IW'(p4_a_q);
    p5_b_q       <= IW'(48) * (IW'(p4_t1_q) + IW'(p4_qt1_q)) - IW'(60) * IW'(p4_su_q);
  end

  // Stage P6: C term, partial y inner sum
  q30_t  p6_su_q, p6_cu_q, p6_sv_q;
  wide_t p6_zin_q, p6_xin_q, p6_c_q, p6_ypart_q;
  always_ff @(posedge clk_i) begin
    p6_su_q    <= p5_su_q;
    p6_cu_q    <= p5_cu_q;
    p6_sv_q    <= p5_sv_q;
    p6_zin_q   <= p5_zin_q;
    p6_xin_q   <= p5_xin_q;
    p6_c_q     <= IW'(80) * (IW'(p5_tc_q) + IW'(p5_qt2_q));
    p6_ypart_q <= IW'(3) * IW'(p5_cv_q) - IW'(3) * IW'(p5_cu2cv_q) - p5_b_q
                + IW'(5) * IW'(p5_a_q) - IW'(5) * IW'(p5_cu3cvsu_q);
  end

  // Stage P7: finish y inner sum
  q30_t  p7_su_q, p7_cu_q, p7_sv_q;
  wide_t p7_zin_q, p7_xin_q, p7_yin_q;
  always_ff @(posedge clk_i) begin
    p7_su_q  <= p6_su_q;
    p7_cu_q  <= p6_cu_q;
    p7_sv_q  <= p6_sv_q;
    p7_zin_q <= p6_zin_q;
    p7_xin_q <= p6_xin_q;
    p7_yin_q <= p6_ypart_q - p6_c_q;
  end

  // Lane operands: inner sum times a sine or cosine
  wide_t lane_in [NUM_LANES];
  q30_t  lane_mul [NUM_LANES];
  assign lane_in[0]  = p7_xin_q;
  assign lane_in[1]  = p7_yin_q;
  assign lane_in[2]  = p7_zin_q;
  assign lane_mul[0] = p7_cu_q;
  assign lane_mul[1] = p7_su_q;
  assign lane_mul[2] = p7_sv_q;

  logic [19+QW:0]    m1_lo_q   [NUM_LANES];
  logic [IW-21+QW:0] m1_hi_q   [NUM_LANES];
  logic              m1_neg_q  [NUM_LANES];
  logic              m1_full_q [NUM_LANES];
  logic [MW-1:0]     m2_m_q    [NUM_LANES];
  logic              m2_neg_q  [NUM_LANES];
  logic [22:0]       m3_n_q    [NUM_LANES];
  logic              m3_ovf_q  [NUM_LANES];
  logic              m3_neg_q  [NUM_LANES];
  logic [19:0]       m4_q_q    [NUM_LANES];
  logic              m4_ovf_q  [NUM_LANES];
  logic              m4_neg_q  [NUM_LANES];
  coord_t            coord_q   [NUM_LANES];

  logic [IW-1:0]     mag_in   [NUM_LANES];
  logic [QW-1:0]     mag_mul  [NUM_LANES];
  logic [IW+QW-1:0]  sum_w    [NUM_LANES];
  logic [IW+QW-31:0] m_w      [NUM_LANES];
  logic [MW:0]       nsum_w   [NUM_LANES];
  logic [MW:0]       n_w      [NUM_LANES];
  logic [46:0]       qprod_w  [NUM_LANES];

  // The rounded product wraps at 64 bits unless the sine or cosine is exactly one
  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      mag_in[l]  = lane_in[l][IW-1] ? (~lane_in[l] + 1'b1) : lane_in[l];
      mag_mul[l] = lane_mul[l][QW-1] ? (~lane_mul[l] + 1'b1) : lane_mul[l];
      sum_w[l]   = {m1_hi_q[l], 20'b0} + (IW+QW)'(m1_lo_q[l]) + (IW+QW)'(1 << 29);
      m_w[l]     = m1_full_q[l] ? sum_w[l][IW+QW-1:30]
                                : (IW+QW-30)'(sum_w[l][63:30]);
      nsum_w[l]  = (MW+1)'(m2_m_q[l]) + HALF_DEN;
      n_w[l]     = nsum_w[l] >> SHIFT_K;
      qprod_w[l] = 47'(m3_n_q[l]) * 47'(RECIP_15);
    end
  end

  // Lane stages M1..M5: split product, round, scale, divide by 15, saturate
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < NUM_LANES; l++) begin
      m1_lo_q[l]   <= (20+QW)'(mag_in[l][19:0]) * (20+QW)'(mag_mul[l]);
      m1_hi_q[l]   <= (IW-20+QW)'(mag_in[l][IW-1:20]) * (IW-20+QW)'(mag_mul[l]);
      m1_neg_q[l]  <= lane_in[l][IW-1] ^ lane_mul[l][QW-1] ^ LANE_NEG[l];
      m1_full_q[l] <= mag_mul[l][30];

      m2_m_q[l]   <= LANE_SHL[l] ? {m_w[l], 1'b0} : {1'b0, m_w[l]};
      m2_neg_q[l] <= m1_neg_q[l];

      m3_ovf_q[l] <= n_w[l] >= (MW+1)'(SAT_N);
      m3_n_q[l]   <= n_w[l][22:0];
      m3_neg_q[l] <= m2_neg_q[l];

      m4_q_q[l]   <= qprod_w[l][RECIP_SHIFT+19:RECIP_SHIFT];
      m4_ovf_q[l] <= m3_ovf_q[l];
      m4_neg_q[l] <= m3_neg_q[l];

      if (m4_neg_q[l]) begin
        coord_q[l] <= (m4_ovf_q[l] || m4_q_q[l] > OUT_NEG_MAG) ? OUT_MIN
                                                               : $signed(~m4_q_q[l] + 1'b1);
      end else begin
        coord_q[l] <= (m4_ovf_q[l] || m4_q_q[l] > OUT_MAX_MAG) ? OUT_MAX
                                                               : $signed(m4_q_q[l]);
      end
    end
  end

  assign coord_x_o = coord_q[0];
  assign coord_y_o = coord_q[1];
  assign coord_z_o = coord_q[2];

  // Every request gives its result at the end of the valid chain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT done_o)
    else $error("request lost in pipeline");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LAT))
    else $error("result without request");

  // Sine and cosine of u stay within the unit range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[8] |-> (p1_su_q <= ONE_Q30 && p1_su_q >= -ONE_Q30 &&
                  p1_cu_q <= ONE_Q30 && p1_cu_q >= -ONE_Q30))
    else $error("sine or cosine out of unit range");

endmodule
